[sv/k_way_sorted_merge_defines.svh]
// ----------------------------------------------------------------------------
// k_way_sorted_merge_defines
// Assertion macros shared by the merge block. They expand to nothing when
// the design is synthesized.
// ----------------------------------------------------------------------------
`ifndef K_WAY_SORTED_MERGE_DEFINES_SVH
`define K_WAY_SORTED_MERGE_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked on every clock edge outside of reset.
`define KWM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("kwm assertion failed");
// Condition in one cycle implies a condition in the next cycle.
`define KWM_ASSERT_NEXT(lbl, cause, effect) \
    `KWM_ASSERT(lbl, (cause) |=> (effect))
`else
`define KWM_ASSERT(lbl, prop)
`define KWM_ASSERT_NEXT(lbl, cause, effect)
`endif

`endif

[sv/kwm_pkg.sv]
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared constants, codes and control types of the k-way merge block.
// ----------------------------------------------------------------------------
`default_nettype none

package kwm_pkg;

    // Default configuration.
    localparam int NUM_LISTS_DEF  = 4;
    localparam int LIST_DEPTH_DEF = 256;

    // Fixed field widths.
    localparam int VALUE_W = 32;
    localparam int CMD_W   = 2;
    localparam int SRC_W   = 2;
    localparam int STS_W   = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // Status codes.
    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

    // Sequencer states.
    typedef enum logic {
        S_IDLE,
        S_FILL
    } t_state;

    // Operation applied to every cell of the head chain alike.
    typedef struct packed {
        logic ins;
        logic pop;
        logic clr;
    } t_chain_op;

    // Operation applied to the list store for the selected list; a clear acts on every list.
    typedef struct packed {
        logic wr;
        logic pop;
        logic mark;
        logic clr;
    } t_store_op;

    // Status of the selected list.
    typedef struct packed {
        logic has_head;
        logic full;
        logic fill_zero;
    } t_store_sts;

endpackage

`default_nettype wire

[sv/kwm_cell.sv]
// ----------------------------------------------------------------------------
// kwm_cell
// One slot of the sorted head chain. It compares the broadcast key with its
// own entry and either keeps it, takes its left neighbor, takes the key,
// takes its right neighbor on a pop, or empties on a clear.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_cell import kwm_pkg::*; #(
    parameter int LIST_W = 2
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_chain_op                 i_op,
    input  wire logic signed [VALUE_W-1:0] i_key_value,
    input  wire logic [LIST_W-1:0]         i_key_list,
    input  wire logic                      i_prev_before,
    input  wire logic                      i_prev_valid,
    input  wire logic signed [VALUE_W-1:0] i_prev_value,
    input  wire logic [LIST_W-1:0]         i_prev_list,
    input  wire logic                      i_next_valid,
    input  wire logic signed [VALUE_W-1:0] i_next_value,
    input  wire logic [LIST_W-1:0]         i_next_list,
    output logic                           o_before,
    output logic                           o_valid,
    output logic signed [VALUE_W-1:0]      o_value,
    output logic [LIST_W-1:0]              o_list
);

    logic                      r_valid;
    logic signed [VALUE_W-1:0] r_value;
    logic [LIST_W-1:0]         r_list;

    // The key sorts ahead of this entry, ties going to the lower list.
    // An empty slot is always behind the key.
    always_comb begin
        o_before = !r_valid || (i_key_value < r_value) ||
                   ((i_key_value == r_value) && (i_key_list < r_list));
    end

    // Occupancy of the slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_op.clr) begin
            r_valid <= 1'b0;
        end else if (i_op.pop) begin
            r_valid <= i_next_valid;
        end else if (i_op.ins && o_before) begin
            r_valid <= i_prev_before ? i_prev_valid : 1'b1;
        end
    end

    // Entry contents move with the occupancy.
    always_ff @(posedge i_clk) begin
        if (i_op.pop) begin
            r_value <= i_next_value;
            r_list  <= i_next_list;
        end else if (i_op.ins && o_before) begin
            if (i_prev_before) begin
                r_value <= i_prev_value;
                r_list  <= i_prev_list;
            end else begin
                r_value <= i_key_value;
                r_list  <= i_key_list;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_list  = r_list;

endmodule

`default_nettype wire

[sv/kwm_head_chain.sv]
// ----------------------------------------------------------------------------
// kwm_head_chain
// Row of head cells kept in ascending order. Slot zero holds the smallest
// head; insert shifts the tail right, pop shifts everything left.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_head_chain import kwm_pkg::*; #(
    parameter int NUM_LISTS = NUM_LISTS_DEF,
    parameter int LIST_W    = $clog2(NUM_LISTS)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_chain_op                 i_op,
    input  wire logic signed [VALUE_W-1:0] i_key_value,
    input  wire logic [LIST_W-1:0]         i_key_list,
    output logic                           o_head_valid,
    output logic signed [VALUE_W-1:0]      o_head_value,
    output logic [LIST_W-1:0]              o_head_list
);

    logic                      w_before [NUM_LISTS];
    logic                      w_valid  [NUM_LISTS];
    logic signed [VALUE_W-1:0] w_value  [NUM_LISTS];
    logic [LIST_W-1:0]         w_list   [NUM_LISTS];

    for (genvar g = 0; g < NUM_LISTS; g++) begin : g_cell
        logic                      w_pv_before;
        logic                      w_pv_valid;
        logic signed [VALUE_W-1:0] w_pv_value;
        logic [LIST_W-1:0]         w_pv_list;
        logic                      w_nb_valid;
        logic signed [VALUE_W-1:0] w_nb_value;
        logic [LIST_W-1:0]         w_nb_list;

        // Left neighbor; the first slot has none.
        if (g == 0) begin : g_first
            assign w_pv_before = 1'b0;
            assign w_pv_valid  = 1'b0;
            assign w_pv_value  = '0;
            assign w_pv_list   = '0;
        end else begin : g_mid
            assign w_pv_before = w_before[g-1];
            assign w_pv_valid  = w_valid[g-1];
            assign w_pv_value  = w_value[g-1];
            assign w_pv_list   = w_list[g-1];
        end

        // Right neighbor; the last slot empties on a pop.
        if (g == NUM_LISTS - 1) begin : g_last
            assign w_nb_valid = 1'b0;
            assign w_nb_value = '0;
            assign w_nb_list  = '0;
        end else begin : g_inner
            assign w_nb_valid = w_valid[g+1];
            assign w_nb_value = w_value[g+1];
            assign w_nb_list  = w_list[g+1];
        end

        kwm_cell #(
            .LIST_W (LIST_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_op          (i_op),
            .i_key_value   (i_key_value),
            .i_key_list    (i_key_list),
            .i_prev_before (w_pv_before),
            .i_prev_valid  (w_pv_valid),
            .i_prev_value  (w_pv_value),
            .i_prev_list   (w_pv_list),
            .i_next_valid  (w_nb_valid),
            .i_next_value  (w_nb_value),
            .i_next_list   (w_nb_list),
            .o_before      (w_before[g]),
            .o_valid       (w_valid[g]),
            .o_value       (w_value[g]),
            .o_list        (w_list[g])
        );
    end

    assign o_head_valid = w_valid[0];
    assign o_head_value = w_value[0];
    assign o_head_list  = w_list[0];

endmodule

`default_nettype wire

[sv/kwm_list_store.sv]
// ----------------------------------------------------------------------------
// kwm_list_store
// Per-list FIFOs behind the heads: one shared memory with a region per list,
// plus write pointer, read pointer, fill count and head flag for each list.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_list_store import kwm_pkg::*; #(
    parameter int NUM_LISTS  = NUM_LISTS_DEF,
    parameter int LIST_DEPTH = LIST_DEPTH_DEF,
    parameter int LIST_W     = $clog2(NUM_LISTS)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_store_op                 i_op,
    input  wire logic [LIST_W-1:0]         i_list,
    input  wire logic signed [VALUE_W-1:0] i_wr_value,
    output t_store_sts                     o_sts,
    output logic signed [VALUE_W-1:0]      o_rd_data
);

    localparam int OFS_W   = $clog2(LIST_DEPTH);
    localparam int FILL_W  = $clog2(LIST_DEPTH + 1);
    localparam int ADDR_W  = LIST_W + OFS_W;
    localparam int MEM_DEP = NUM_LISTS << OFS_W;

    logic signed [VALUE_W-1:0] r_mem [MEM_DEP];
    logic signed [VALUE_W-1:0] r_rd_data;
    logic [OFS_W-1:0]          r_wptr [NUM_LISTS];
    logic [OFS_W-1:0]          r_rptr [NUM_LISTS];
    logic [FILL_W-1:0]         r_fill [NUM_LISTS];
    logic                      r_head [NUM_LISTS];
    logic [ADDR_W-1:0]         w_wr_addr;
    logic [ADDR_W-1:0]         w_rd_addr;

    // Per-list bookkeeping lanes.
    for (genvar g = 0; g < NUM_LISTS; g++) begin : g_lane
        logic w_sel;

        assign w_sel = (i_list == LIST_W'(g));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n || i_op.clr) begin
                r_wptr[g] <= '0;
                r_rptr[g] <= '0;
                r_fill[g] <= '0;
                r_head[g] <= 1'b0;
            end else if (w_sel) begin
                if (i_op.wr) begin
                    r_wptr[g] <= (r_wptr[g] == OFS_W'(LIST_DEPTH - 1)) ?
                                 '0 : r_wptr[g] + OFS_W'(1);
                    r_fill[g] <= r_fill[g] + FILL_W'(1);
                end
                if (i_op.pop) begin
                    if (r_fill[g] == '0) begin
                        r_head[g] <= 1'b0;
                    end else begin
                        r_rptr[g] <= (r_rptr[g] == OFS_W'(LIST_DEPTH - 1)) ?
                                     '0 : r_rptr[g] + OFS_W'(1);
                        r_fill[g] <= r_fill[g] - FILL_W'(1);
                    end
                end
                if (i_op.mark) begin
                    r_head[g] <= 1'b1;
                end
            end
        end
    end

    // Status of the selected list.
    always_comb begin
        o_sts.has_head  = r_head[i_list];
        o_sts.full      = (r_fill[i_list] == FILL_W'(LIST_DEPTH));
        o_sts.fill_zero = (r_fill[i_list] == '0);
    end

    assign w_wr_addr = {i_list, r_wptr[i_list]};
    assign w_rd_addr = {i_list, r_rptr[i_list]};

    // Value memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_op.wr) begin
            r_mem[w_wr_addr] <= i_wr_value;
        end
        if (i_op.pop) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[sv/k_way_sorted_merge.sv]
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// K-way merge of sorted lists: per-list FIFOs feeding a sorted chain of heads.
// ----------------------------------------------------------------------------
// Append, clear, the unused command code and any pop that leaves no queued
// value to promote complete without a refill step. A pop whose list still
// holds queued values goes through S_IDLE and then S_FILL: in S_IDLE it
// removes the smallest head from the cell chain and reads the list memory,
// in S_FILL it inserts the value read into the chain, and the input is
// stalled during S_FILL. One result beat is produced per command and is held
// in an output register, so outside a refill a new command is taken as soon
// as the previous result has left or is leaving. The list memory has no
// clearing pass; the block accepts commands from the first cycle after reset.
`default_nettype none

`include "k_way_sorted_merge_defines.svh"

module k_way_sorted_merge import kwm_pkg::*; #(
    parameter int NUM_LISTS  = NUM_LISTS_DEF,
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [CMD_W-1:0]          i_command,
    input  wire logic [SRC_W-1:0]          i_list_index,
    input  wire logic signed [VALUE_W-1:0] i_value,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic signed [VALUE_W-1:0]      o_out_value,
    output logic [SRC_W-1:0]               o_source_list,
    output logic [STS_W-1:0]               o_status
);

    localparam int LIST_W = $clog2(NUM_LISTS);

    t_state                    r_state;
    t_state                    n_state;
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_value;
    logic [SRC_W-1:0]          r_out_list;
    logic [STS_W-1:0]          r_out_status;
    logic [LIST_W-1:0]         r_fill_list;

    logic                      w_accept;
    logic                      w_bad_list;
    logic [LIST_W-1:0]         w_list;
    logic [LIST_W-1:0]         w_store_list;
    t_chain_op                 w_chain_op;
    t_store_op                 w_store_op;
    t_store_sts                w_sts;
    logic signed [VALUE_W-1:0] w_key_value;
    logic [LIST_W-1:0]         w_key_list;
    logic signed [VALUE_W-1:0] w_rd_data;
    logic                      w_head_valid;
    logic signed [VALUE_W-1:0] w_head_value;
    logic [LIST_W-1:0]         w_head_list;
    logic signed [VALUE_W-1:0] w_res_value;
    logic [SRC_W-1:0]          w_res_list;
    logic [STS_W-1:0]          w_res_status;

    // Input handshake: busy during a refill or while the result is blocked.
    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_bad_list   = (32'(i_list_index) >= 32'(NUM_LISTS));
    assign w_list       = LIST_W'(i_list_index);
    assign w_store_list = (i_command == CMD_POP) ? w_head_list : w_list;

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Command decode, next state and result.
    always_comb begin
        n_state      = r_state;
        w_chain_op   = '0;
        w_store_op   = '0;
        w_key_value  = i_value;
        w_key_list   = w_list;
        w_res_value  = '0;
        w_res_list   = '0;
        w_res_status = STS_OK;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_command)
                        CMD_APPEND: begin
                            if (w_bad_list) begin
                                w_res_status = STS_FULL;
                            end else if (!w_sts.has_head) begin
                                w_chain_op.ins  = 1'b1;
                                w_store_op.mark = 1'b1;
                            end else if (w_sts.full) begin
                                w_res_status = STS_FULL;
                            end else begin
                                w_store_op.wr = 1'b1;
                            end
                        end
                        CMD_POP: begin
                            if (!w_head_valid) begin
                                w_res_status = STS_EMPTY;
                            end else begin
                                w_res_value    = w_head_value;
                                w_res_list     = SRC_W'(w_head_list);
                                w_chain_op.pop = 1'b1;
                                w_store_op.pop = 1'b1;
                                if (!w_sts.fill_zero) begin
                                    n_state = S_FILL;
                                end
                            end
                        end
                        CMD_CLEAR: begin
                            w_chain_op.clr = 1'b1;
                            w_store_op.clr = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL: begin
                // Promote the value read from the popped list.
                w_chain_op.ins = 1'b1;
                w_key_value    = w_rd_data;
                w_key_list     = r_fill_list;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // List that is refilled after a pop.
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_command == CMD_POP)) begin
            r_fill_list <= w_head_list;
        end
    end

    // Output register: one result beat per command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_value  <= w_res_value;
            r_out_list   <= w_res_list;
            r_out_status <= w_res_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_value   = r_out_value;
    assign o_source_list = r_out_list;
    assign o_status      = r_out_status;

    kwm_head_chain #(
        .NUM_LISTS (NUM_LISTS),
        .LIST_W    (LIST_W)
    ) u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (w_chain_op),
        .i_key_value  (w_key_value),
        .i_key_list   (w_key_list),
        .o_head_valid (w_head_valid),
        .o_head_value (w_head_value),
        .o_head_list  (w_head_list)
    );

    kwm_list_store #(
        .NUM_LISTS  (NUM_LISTS),
        .LIST_DEPTH (LIST_DEPTH),
        .LIST_W     (LIST_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_store_op),
        .i_list     (w_store_list),
        .i_wr_value (i_value),
        .o_sts      (w_sts),
        .o_rd_data  (w_rd_data)
    );

    // A refill is always followed by the idle state.
    `KWM_ASSERT_NEXT(a_fill_one_cycle, r_state == S_FILL, r_state == S_IDLE)
    // After a refill the chain holds at least the promoted head.
    `KWM_ASSERT_NEXT(a_fill_leaves_head, r_state == S_FILL, w_head_valid)
    // A pop taken with a head present reports success.
    `KWM_ASSERT_NEXT(a_pop_ok, w_accept && (i_command == CMD_POP) && w_head_valid,
                     r_out_valid && (r_out_status == STS_OK))
    // A clear leaves no heads behind.
    `KWM_ASSERT_NEXT(a_clear_empties, w_accept && (i_command == CMD_CLEAR), !w_head_valid)

endmodule

`default_nettype wire
